>>> rtl/rdf_pkg.sv
// Shared constants and control types for the radix digit formatter.
`timescale 1ns / 1ps

package rdf_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_RADIX_DEF  = 36;

  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 7;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
  localparam logic [RADIX_W-1:0] DEC_BASE  = 6'd10;
  localparam logic [RADIX_W-1:0] MIN_RADIX = 6'd2;

  typedef struct packed {
    logic load;
    logic div_step;
    logic store_digit;
    logic emit_err;
    logic emit_sign;
    logic rd_issue;
    logic emit_digit;
  } rdf_cmd_t;

  typedef struct packed {
    logic bad_radix;
    logic negative;
    logic div_last;
    logic quot_zero;
    logic count_zero;
    logic out_taken;
  } rdf_sts_t;

endpackage

>>> rtl/rdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rdf_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rdf_datapath.sv
// Datapath: operand registers, bit-serial divider, digit stack and output register.
`timescale 1ns / 1ps

module rdf_datapath #(
  parameter int VALUE_BITS = rdf_pkg::VALUE_BITS_DEF,
  parameter int MAX_RADIX  = rdf_pkg::MAX_RADIX_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rdf_pkg::rdf_cmd_t                cmd_i,
  output rdf_pkg::rdf_sts_t                sts_o,
  input  logic signed [VALUE_BITS-1:0]     value_i,
  input  logic [rdf_pkg::RADIX_W-1:0]      radix_i,
  input  logic                             upper_case_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [rdf_pkg::CHAR_W-1:0]       out_char_o,
  output logic                             last_char_o,
  output logic                             bad_radix_o
);

  localparam int BCW = $clog2(VALUE_BITS);
  localparam int AW  = $clog2(VALUE_BITS);
  localparam int CW  = $clog2(VALUE_BITS + 1);
  localparam int RW  = rdf_pkg::RADIX_W;
  localparam int CHW = rdf_pkg::CHAR_W;

  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [RW-1:0]         rem_q, rem_d;
  logic [RW-1:0]         radix_q;
  logic                  upper_q;
  logic                  neg_q;
  logic                  bad_q;
  logic [BCW-1:0]        bit_cnt_q, bit_cnt_d;
  logic [CW-1:0]         dig_cnt_q, dig_cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic [CHW-1:0]        out_char_q;
  logic                  last_q;
  logic                  bad_out_q;

  logic [RW:0]           trial;
  logic                  ge;
  logic [RW:0]           diff;
  logic [RW-1:0]         rd_digit;
  logic [CHW-1:0]        digit_char;
  logic [VALUE_BITS-1:0] value_u;

  assign value_u = value_i;
  assign trial   = {rem_q, mag_q[VALUE_BITS-1]};
  assign ge      = trial >= {1'b0, radix_q};
  assign diff    = trial - {1'b0, radix_q};

  always_comb begin
    mag_d     = mag_q;
    rem_d     = rem_q;
    bit_cnt_d = bit_cnt_q;
    dig_cnt_d = dig_cnt_q;
    if (cmd_i.load) begin
      mag_d     = value_u[VALUE_BITS-1] ? (~value_u + 1'b1) : value_u;
      rem_d     = '0;
      bit_cnt_d = '0;
      dig_cnt_d = '0;
    end else if (cmd_i.div_step) begin
      mag_d     = {mag_q[VALUE_BITS-2:0], ge};
      rem_d     = ge ? diff[RW-1:0] : trial[RW-1:0];
      bit_cnt_d = bit_cnt_q + 1'b1;
    end else if (cmd_i.store_digit) begin
      rem_d     = '0;
      bit_cnt_d = '0;
      dig_cnt_d = dig_cnt_q + 1'b1;
    end else if (cmd_i.rd_issue) begin
      dig_cnt_d = dig_cnt_q - 1'b1;
    end
  end

  always_comb begin
    if (rd_digit < rdf_pkg::DEC_BASE) begin
      digit_char = rdf_pkg::CHAR_ZERO + {1'b0, rd_digit};
    end else begin
      digit_char = (upper_q ? rdf_pkg::CHAR_UPPER : rdf_pkg::CHAR_LOWER)
                   + {1'b0, rd_digit - rdf_pkg::DEC_BASE};
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.emit_err || cmd_i.emit_sign || cmd_i.emit_digit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    if (cmd_i.load) begin
      radix_q <= radix_i;
      upper_q <= upper_case_i;
      neg_q   <= value_u[VALUE_BITS-1];
      bad_q   <= (radix_i < rdf_pkg::MIN_RADIX) || (radix_i > RW'(MAX_RADIX));
    end
    if (cmd_i.emit_err) begin
      out_char_q <= rdf_pkg::CHAR_NONE;
      last_q     <= 1'b1;
      bad_out_q  <= 1'b1;
    end else if (cmd_i.emit_sign) begin
      out_char_q <= rdf_pkg::CHAR_MINUS;
      last_q     <= 1'b0;
      bad_out_q  <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      out_char_q <= digit_char;
      last_q     <= (dig_cnt_q == '0);
      bad_out_q  <= 1'b0;
    end
  end

  rdf_ram #(
    .WIDTH (RW),
    .DEPTH (VALUE_BITS)
  ) u_digits (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store_digit),
    .waddr_i (dig_cnt_q[AW-1:0]),
    .wdata_i (rem_q),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (dig_cnt_d[AW-1:0]),
    .rdata_o (rd_digit)
  );

  assign sts_o.bad_radix  = bad_q;
  assign sts_o.negative   = neg_q;
  assign sts_o.div_last   = (bit_cnt_q == BCW'(VALUE_BITS - 1));
  assign sts_o.quot_zero  = (mag_q == '0);
  assign sts_o.count_zero = (dig_cnt_q == '0);
  assign sts_o.out_taken  = out_valid_q && !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = last_q;
  assign bad_radix_o = bad_out_q;

endmodule

>>> rtl/rdf_ctrl.sv
// Controller: sequences load, division, digit stacking and character output.
`timescale 1ns / 1ps

module rdf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rdf_pkg::rdf_sts_t sts_i,
  output rdf_pkg::rdf_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    IDLE,
    CHECK,
    DIV,
    STORE,
    SIGN,
    SIGN_WAIT,
    READ,
    LOAD,
    DIG_WAIT,
    ERR_WAIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = CHECK;
        end
      end
      CHECK: begin
        if (sts_i.bad_radix) begin
          cmd_o.emit_err = 1'b1;
          state_d        = ERR_WAIT;
        end else begin
          state_d = DIV;
        end
      end
      DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = STORE;
        end
      end
      STORE: begin
        cmd_o.store_digit = 1'b1;
        if (!sts_i.quot_zero) begin
          state_d = DIV;
        end else if (sts_i.negative) begin
          state_d = SIGN;
        end else begin
          state_d = READ;
        end
      end
      SIGN: begin
        cmd_o.emit_sign = 1'b1;
        state_d         = SIGN_WAIT;
      end
      SIGN_WAIT: begin
        if (sts_i.out_taken) begin
          state_d = READ;
        end
      end
      READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = LOAD;
      end
      LOAD: begin
        cmd_o.emit_digit = 1'b1;
        state_d          = DIG_WAIT;
      end
      DIG_WAIT: begin
        if (sts_i.out_taken) begin
          state_d = sts_i.count_zero ? IDLE : READ;
        end
      end
      ERR_WAIT: begin
        if (sts_i.out_taken) begin
          state_d = IDLE;
        end
      end
      default: begin
        state_d = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != IDLE);

endmodule

>>> rtl/radix_digit_formatter.sv
// Top level of the radix digit formatter: controller plus datapath.
// Steps: an accepted input is loaded (IDLE) and its radix checked (CHECK); each digit is then
// found by bit-serial division steps (DIV) and pushed on the digit stack (STORE). Output runs
// SIGN, SIGN_WAIT for a minus sign, then READ, LOAD, DIG_WAIT for each digit; a bad radix gives
// one error character (ERR_WAIT). One item at a time: in_stall_o stays high until the item's last
// character is taken; reset (rst_ni low, asynchronous) idles the controller, drops output.
`timescale 1ns / 1ps

module radix_digit_formatter #(
  parameter int VALUE_BITS = rdf_pkg::VALUE_BITS_DEF,
  parameter int MAX_RADIX  = rdf_pkg::MAX_RADIX_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  input  logic [rdf_pkg::RADIX_W-1:0]  radix_i,
  input  logic                         upper_case_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rdf_pkg::CHAR_W-1:0]   out_char_o,
  output logic                         last_char_o,
  output logic                         bad_radix_o
);

  rdf_pkg::rdf_cmd_t cmd;
  rdf_pkg::rdf_sts_t sts;

  rdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rdf_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_RADIX  (MAX_RADIX)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .value_i      (value_i),
    .radix_i      (radix_i),
    .upper_case_i (upper_case_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .last_char_o  (last_char_o),
    .bad_radix_o  (bad_radix_o)
  );

endmodule

>>> tb/radix_digit_formatter_test.sv
// Self-checking testbench for radix_digit_formatter: corner and random values, checked per character.
`timescale 1ns / 1ps

module radix_digit_formatter_test;

  localparam int VBITS          = rdf_pkg::VALUE_BITS_DEF;
  localparam int RW             = rdf_pkg::RADIX_W;
  localparam int CW             = rdf_pkg::CHAR_W;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 40;

  localparam logic [VBITS-1:0] MOST_NEG  = {1'b1, {(VBITS-1){1'b0}}};
  localparam logic [VBITS-1:0] MOST_POS  = {1'b0, {(VBITS-1){1'b1}}};
  localparam logic [RW-1:0]    TOP_RADIX = RW'(rdf_pkg::MAX_RADIX_DEF);

  typedef struct packed {
    logic [CW-1:0] ch;
    logic          last;
    logic          bad;
  } char_t;

  class radix_string_board;
    char_t expected_chars[$];
    int    mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    task report_mismatch(string msg);
      $display("%0t ns mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    function void note_item(logic [VBITS-1:0] value, logic [RW-1:0] radix, logic upper);
      bit [VBITS-1:0] mag;
      bit [RW-1:0]    dig;
      char_t          digits[$];
      char_t          c;
      if (radix < rdf_pkg::MIN_RADIX || radix > TOP_RADIX) begin
        c.ch   = rdf_pkg::CHAR_NONE;
        c.last = 1'b1;
        c.bad  = 1'b1;
        expected_chars.push_back(c);
        return;
      end
      mag = value[VBITS-1] ? ~value + 1'b1 : value;
      do begin
        dig = RW'(mag % radix);
        if (dig < rdf_pkg::DEC_BASE) begin
          c.ch = rdf_pkg::CHAR_ZERO + {1'b0, dig};
        end else begin
          c.ch = (upper ? rdf_pkg::CHAR_UPPER : rdf_pkg::CHAR_LOWER)
                 + {1'b0, dig - rdf_pkg::DEC_BASE};
        end
        c.last = (digits.size() == 0);
        c.bad  = 1'b0;
        digits.push_front(c);
        mag = mag / radix;
      end while (mag != 0);
      if (value[VBITS-1]) begin
        c.ch   = rdf_pkg::CHAR_MINUS;
        c.last = 1'b0;
        c.bad  = 1'b0;
        expected_chars.push_back(c);
      end
      foreach (digits[i]) expected_chars.push_back(digits[i]);
    endfunction

    task check_char(logic [CW-1:0] ch, logic last, logic bad);
      char_t want;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("char %h arrived with nothing expected", ch));
        return;
      end
      want = expected_chars.pop_front();
      if (ch !== want.ch) begin
        report_mismatch($sformatf("out_char %h, expected %h", ch, want.ch));
      end
      if (last !== want.last) begin
        report_mismatch($sformatf("last_char %b, expected %b", last, want.last));
      end
      if (bad !== want.bad) begin
        report_mismatch($sformatf("bad_radix %b, expected %b", bad, want.bad));
      end
    endtask
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [VBITS-1:0]  value_i;
  logic [RW-1:0]            radix_i;
  logic                     upper_case_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [CW-1:0]            out_char_o;
  logic                     last_char_o;
  logic                     bad_radix_o;

  radix_string_board board;
  bit                tx_idle_on;
  bit                rx_idle_on;
  bit                hold_request;

  radix_digit_formatter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .radix_i      (radix_i),
    .upper_case_i (upper_case_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .last_char_o  (last_char_o),
    .bad_radix_o  (bad_radix_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic send_item(logic [VBITS-1:0] v, logic [RW-1:0] r, logic u);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    value_i      <= v;
    radix_i      <= r;
    upper_case_i <= u;
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(v, r, u);
  endtask

  task automatic send_random(int count);
    logic [VBITS-1:0] v;
    logic [RW-1:0]    r;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: v = $urandom();
        4:          v = $urandom() >> $urandom_range(1, 31);
        5, 6, 7:    v = $urandom_range(0, 2000) - 1000;
        8:          v = -($urandom() >> $urandom_range(1, 31));
        default: begin
          case ($urandom_range(0, 3))
            0:       v = '0;
            1:       v = '1;
            2:       v = MOST_NEG;
            default: v = MOST_POS;
          endcase
        end
      endcase
      if ($urandom_range(0, 11) == 0) begin
        r = $urandom_range(0, 1) ? RW'($urandom_range(rdf_pkg::MAX_RADIX_DEF + 1, 63))
                                 : RW'($urandom_range(0, 1));
      end else begin
        r = RW'($urandom_range(rdf_pkg::MIN_RADIX, rdf_pkg::MAX_RADIX_DEF));
      end
      send_item(v, r, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  initial begin : char_sink
    int gap;
    out_stall_i <= 1'b0;
    forever begin
      gap = rx_idle_on ? $urandom_range(0, 5) : 0;
      if (hold_request) begin
        hold_request = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      board.check_char(out_char_o, last_char_o, bad_radix_o);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("radix_digit_formatter_test NOT OK");
    $finish;
  end

  initial begin
    board        = new();
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    hold_request = 1'b0;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    value_i      <= '0;
    radix_i      <= '0;
    upper_case_i <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item('0, rdf_pkg::DEC_BASE, 1'b0);
    send_item(MOST_POS, rdf_pkg::MIN_RADIX, 1'b0);
    send_item(MOST_NEG, rdf_pkg::MIN_RADIX, 1'b1);
    send_item('1, rdf_pkg::MIN_RADIX, 1'b0);
    send_item(MOST_NEG, TOP_RADIX, 1'b1);
    send_item(MOST_NEG, TOP_RADIX, 1'b0);
    send_item(MOST_POS, TOP_RADIX, 1'b1);
    send_item(MOST_POS, TOP_RADIX, 1'b0);
    send_item(35, TOP_RADIX, 1'b1);
    send_item(35, TOP_RADIX, 1'b0);
    send_item(-255, 16, 1'b1);
    send_item(MOST_NEG, rdf_pkg::DEC_BASE, 1'b0);
    send_item(123456789, rdf_pkg::DEC_BASE, 1'b0);
    send_item(10, 11, 1'b0);
    send_item(-64, 8, 1'b1);
    send_item(100, 3, 1'b0);
    send_item(42, 0, 1'b0);
    send_item(-7, 1, 1'b1);
    send_item(MOST_NEG, TOP_RADIX + 1'b1, 1'b0);
    send_item('1, 63, 1'b1);
    send_item('0, rdf_pkg::MIN_RADIX, 1'b1);
    send_item(1, TOP_RADIX, 1'b0);

    send_random(100);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_random(90);
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    hold_request = 1'b1;
    send_random(100);
    drain_results();
    rx_idle_on = 1'b0;
    send_random(50);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    send_random(50);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("radix_digit_formatter_test OK");
    end else begin
      $display("radix_digit_formatter_test NOT OK");
    end
    $finish;
  end

endmodule
